/* rtl/ugsi_pkg.sv */
// Shared types and constants of the uniform grid spatial index.
// No dependencies; every other file but ugsi_ram imports this package.
`timescale 1ns / 1ps

package ugsi_pkg;

  // default sizes of the grid and the stores
  localparam int GRID_DIM_DEF   = 64;
  localparam int CELL_SLOTS_DEF = 8;
  localparam int MAX_ITEMS_DEF  = 64;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int ID_W    = 6;
  localparam int COORD_W = 32;
  localparam int EDGE_W  = 31;
  localparam int CRD_W   = 10;   // cell coordinate, wide enough for the largest grid

  localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLIPPED = 3'd4
  } status_t;

  // classified request handed from the front part to the back part
  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [CRD_W-1:0] x0;
    logic [CRD_W-1:0] x1;
    logic [CRD_W-1:0] y0;
    logic [CRD_W-1:0] y1;
    logic             empty;
    logic             clipped;
  } cmd_t;

  // one result
  typedef struct packed {
    logic [ID_W-1:0] found_id;
    logic            found_valid;
    logic            last;
    status_t         status;
  } res_t;

endpackage

/* rtl/uniform_grid_spatial_index.sv */
// Uniform grid spatial index (broad phase) over a GRID_DIM x GRID_DIM field of
// square cells, up to CELL_SLOTS items per cell and MAX_ITEMS item handles.
// Requests enter through a queue-style port (push/full) and results leave through
// another (empty/pop); add, remove and clear give one result, a query one result
// per distinct item found (one if none), with last on the final one. An add or
// query first computes the cell range in the front part with a serial divider (one
// quotient bit per cycle); the back part then picks up the request and walks the
// covered cells in the cell memories: an add walks them twice (capacity check, then
// filing), a remove or query reads each cell's fill count and then its stored
// slots (a remove first fetches the item's cell range, a query waits while the
// result queue is full), and each request ends with a final result. A clear, and
// the clearing pass after reset, sweep the GRID_DIM * GRID_DIM cells of the
// fill-count memory one cell per cycle, during which no request is taken from
// the internal queue. Front and back overlap through a two-entry request queue,
// and a four-entry result queue lets the back part run ahead of a slow reader.
// Uses ugsi_pkg, ugsi_front, ugsi_cmdq and ugsi_back.
`timescale 1ns / 1ps

module uniform_grid_spatial_index import ugsi_pkg::*; #(
  parameter int GRID_DIM   = GRID_DIM_DEF,
  parameter int CELL_SLOTS = CELL_SLOTS_DEF,
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [OP_W-1:0]    in_op,
  input  logic [ID_W-1:0]    in_item_id,
  input  logic [COORD_W-1:0] in_rect_x,
  input  logic [COORD_W-1:0] in_rect_y,
  input  logic [COORD_W-1:0] in_rect_w,
  input  logic [COORD_W-1:0] in_rect_h,
  output logic               empty,
  input  logic               pop,
  output logic [ID_W-1:0]    out_found_id,
  output logic               out_found_valid,
  output logic               out_last,
  output logic [2:0]         out_status,
  input  logic               cfg_we,
  input  logic [EDGE_W-1:0]  cfg_wdata
);

  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  res_t res;

  // request classification
  ugsi_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_op      (in_op),
    .in_item_id (in_item_id),
    .in_rect_x  (in_rect_x),
    .in_rect_y  (in_rect_y),
    .in_rect_w  (in_rect_w),
    .in_rect_h  (in_rect_h),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  // decoupling queue
  ugsi_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cmd_push),
    .wdata   (cmd_in),
    .q_full  (cmd_full),
    .rd      (cmd_pop),
    .q_empty (cmd_empty),
    .rdata   (cmd_head)
  );

  // cell store and walker
  ugsi_back #(
    .GRID_DIM   (GRID_DIM),
    .CELL_SLOTS (CELL_SLOTS),
    .MAX_ITEMS  (MAX_ITEMS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_empty (empty),
    .res_pop   (pop),
    .res       (res)
  );

  assign out_found_id    = res.found_id;
  assign out_found_valid = res.found_valid;
  assign out_last        = res.last;
  assign out_status      = res.status;

endmodule

/* rtl/ugsi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ugsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/ugsi_front.sv */
// Front part: takes requests, holds the cell edge register and turns each
// rectangle into a clipped cell range with a shared serial divider. Uses ugsi_pkg.
`timescale 1ns / 1ps

module ugsi_front import ugsi_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [OP_W-1:0]    in_op,
  input  logic [ID_W-1:0]    in_item_id,
  input  logic [COORD_W-1:0] in_rect_x,
  input  logic [COORD_W-1:0] in_rect_y,
  input  logic [COORD_W-1:0] in_rect_w,
  input  logic [COORD_W-1:0] in_rect_h,
  input  logic               cfg_we,
  input  logic [EDGE_W-1:0]  cfg_wdata,
  input  logic               cmd_full,
  output logic               cmd_push,
  output cmd_t               cmd
);

  localparam int QW   = $clog2(GRID_DIM);
  localparam int LW   = EDGE_W + QW + 1;
  localparam int XW   = COORD_W + 1 + QW;
  localparam int CNTW = $clog2(QW + 1);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_LOAD = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t               state_r;
  op_t                   op_r;
  logic [ID_W-1:0]       id_r;
  logic [COORD_W:0]      opnd_r [4];
  logic                  wneg_r;
  logic                  hneg_r;
  logic [EDGE_W-1:0]     edge_r;
  logic [LW-1:0]         limit_r;
  logic [1:0]            idx_r;
  logic [XW-1:0]         rem_r;
  logic [XW-1:0]         div_r;
  logic [QW-1:0]         q_r;
  logic [CNTW-1:0]       cnt_r;
  logic [QW-1:0]         qv_r [4];
  logic [3:0]            neg_r;
  logic [3:0]            ge_r;

  logic                  accept;
  logic [COORD_W:0]      opnd;
  logic                  step_ge;
  logic [QW-1:0]         q_nxt;
  logic [QW-1:0]         lx0, lx1, ly0, ly1;
  logic                  xclip, yclip, xempty, yempty;

  assign accept   = push && !full;
  assign full     = (state_r != F_IDLE);
  assign cmd_push = (state_r == F_PUSH) && !cmd_full;
  assign opnd     = opnd_r[idx_r];

  // one quotient bit per cycle
  assign step_ge = (rem_r >= div_r);
  assign q_nxt   = QW'({q_r, step_ge});

  // cell edge register, a zero write is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r <= EDGE_RESET;
    end else if (cfg_we && (cfg_wdata != '0)) begin
      edge_r <= cfg_wdata;
    end
  end

  // grid extent in raw units
  always_ff @(posedge clk) begin
    limit_r <= LW'(edge_r) * LW'(GRID_DIM);
  end

  // sequencer over the left, right, top and bottom edge values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            op_r      <= op_t'(in_op);
            id_r      <= in_item_id;
            opnd_r[0] <= {in_rect_x[COORD_W-1], in_rect_x};
            opnd_r[1] <= {in_rect_x[COORD_W-1], in_rect_x} + {in_rect_w[COORD_W-1], in_rect_w};
            opnd_r[2] <= {in_rect_y[COORD_W-1], in_rect_y};
            opnd_r[3] <= {in_rect_y[COORD_W-1], in_rect_y} + {in_rect_h[COORD_W-1], in_rect_h};
            wneg_r    <= in_rect_w[COORD_W-1];
            hneg_r    <= in_rect_h[COORD_W-1];
            idx_r     <= '0;
            if (op_t'(in_op) == OP_ADD || op_t'(in_op) == OP_QUERY) begin
              state_r <= F_LOAD;
            end else begin
              state_r <= F_PUSH;
            end
          end
        end
        F_LOAD: begin
          rem_r        <= XW'(opnd);
          div_r        <= XW'(edge_r) << (QW - 1);
          q_r          <= '0;
          cnt_r        <= '0;
          neg_r[idx_r] <= opnd[COORD_W];
          ge_r[idx_r]  <= !opnd[COORD_W] && (XW'(opnd) >= XW'(limit_r));
          state_r      <= F_DIV;
        end
        F_DIV: begin
          if (step_ge) begin
            rem_r <= rem_r - div_r;
          end
          div_r <= div_r >> 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(QW - 1)) begin
            qv_r[idx_r] <= q_nxt;
            if (idx_r == 2'd3) begin
              state_r <= F_PUSH;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= F_LOAD;
            end
          end
        end
        F_PUSH: begin
          if (!cmd_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // clip the ranges to the grid and flag empty and clipped ranges
  always_comb begin
    lx0    = neg_r[0] ? '0 : qv_r[0];
    lx1    = ge_r[1] ? QW'(GRID_DIM - 1) : qv_r[1];
    ly0    = neg_r[2] ? '0 : qv_r[2];
    ly1    = ge_r[3] ? QW'(GRID_DIM - 1) : qv_r[3];
    xclip  = !wneg_r && (neg_r[0] || ge_r[1]);
    yclip  = !hneg_r && (neg_r[2] || ge_r[3]);
    xempty = wneg_r || ge_r[0] || neg_r[1];
    yempty = hneg_r || ge_r[2] || neg_r[3];

    cmd.op      = op_r;
    cmd.id      = id_r;
    cmd.x0      = CRD_W'(lx0);
    cmd.x1      = CRD_W'(lx1);
    cmd.y0      = CRD_W'(ly0);
    cmd.y1      = CRD_W'(ly1);
    cmd.empty   = xempty || yempty;
    cmd.clipped = xclip || yclip;
  end

endmodule

/* rtl/ugsi_cmdq.sv */
// Two-entry request queue between the front and back parts.
// Uses ugsi_pkg for the request type.
`timescale 1ns / 1ps

module ugsi_cmdq import ugsi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wdata,
  output logic q_full,
  input  logic rd,
  output logic q_empty,
  output cmd_t rdata
);

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rdata   = ent_r[rp_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      ent_r[wp_r] <= wdata;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr && !q_full) begin
        wp_r <= !wp_r;
      end
      if (rd && !q_empty) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'((wr && !q_full) ? 1 : 0) - 2'((rd && !q_empty) ? 1 : 0);
    end
  end

endmodule

/* rtl/ugsi_back.sv */
// Back part: walks the covered cells in the cell memories, files, erases and
// finds items, and queues the results. Uses ugsi_pkg and ugsi_ram.
`timescale 1ns / 1ps

module ugsi_back import ugsi_pkg::*; #(
  parameter int GRID_DIM   = GRID_DIM_DEF,
  parameter int CELL_SLOTS = CELL_SLOTS_DEF,
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic res_empty,
  input  logic res_pop,
  output res_t res
);

  localparam int QW       = $clog2(GRID_DIM);
  localparam int NCELL    = GRID_DIM * GRID_DIM;
  localparam int CAW      = $clog2(NCELL);
  localparam int NSLOT    = NCELL * CELL_SLOTS;
  localparam int SAW      = $clog2(NSLOT);
  localparam int FW       = $clog2(CELL_SLOTS + 1);
  localparam int IDW      = $clog2(MAX_ITEMS);
  localparam int RW       = 4 * QW;
  localparam int OQ_DEPTH = 4;

  typedef enum logic [7:0] {
    B_CLR  = 8'b0000_0001,
    B_IDLE = 8'b0000_0010,
    B_RECT = 8'b0000_0100,
    B_FRD  = 8'b0000_1000,
    B_FEV  = 8'b0001_0000,
    B_SRD  = 8'b0010_0000,
    B_SEV  = 8'b0100_0000,
    B_DONE = 8'b1000_0000
  } bstate_t;

  bstate_t              state_r;
  op_t                  op_r;
  logic                 chk_r;
  logic [IDW-1:0]       id_r;
  logic [QW-1:0]        x0_r, x1_r, y0_r, y1_r;
  logic [QW-1:0]        cx_r, cy_r;
  logic [FW-1:0]        n_r;
  logic [FW-1:0]        j_r;
  logic                 found_r;
  status_t              status_r;
  logic                 pend_v_r;
  logic [IDW-1:0]       pend_id_r;
  logic [MAX_ITEMS-1:0] present_r;
  logic [MAX_ITEMS-1:0] seen_r;
  logic [CAW-1:0]       clr_cnt_r;
  logic                 clr_emit_r;
  res_t                 oq_r [OQ_DEPTH];
  logic [1:0]           oq_wp_r;
  logic [1:0]           oq_rp_r;
  logic [2:0]           oq_cnt_r;

  logic                 fill_we, fill_re;
  logic [CAW-1:0]       fill_waddr;
  logic [FW-1:0]        fill_wdata, fill_rd;
  logic                 slot_we, slot_re;
  logic [SAW-1:0]       slot_waddr, slot_raddr, slot_base;
  logic [IDW-1:0]       slot_wdata, slot_rd;
  logic                 rect_we, rect_re;
  logic [RW-1:0]        rect_rd;
  logic [CAW-1:0]       cell_addr;
  logic                 last_cell;
  logic                 seen_hit;
  logic                 room;
  logic                 stall;
  logic                 oq_push, oq_pop;
  res_t                 oq_data;
  logic                 id_oor;
  logic [QW-1:0]        cx_adv, cy_adv;

  // cell and slot addressing
  assign cell_addr  = CAW'(cx_r) * CAW'(GRID_DIM) + CAW'(cy_r);
  assign slot_base  = SAW'(cell_addr) * SAW'(CELL_SLOTS);
  assign slot_raddr = slot_base + SAW'(j_r);
  assign last_cell  = (cx_r == x1_r) && (cy_r == y1_r);
  assign cx_adv     = (cy_r == y1_r) ? cx_r + QW'(1) : cx_r;
  assign cy_adv     = (cy_r == y1_r) ? y0_r : cy_r + QW'(1);

  assign seen_hit = !seen_r[slot_rd];
  assign room     = (oq_cnt_r != 3'(OQ_DEPTH));
  assign stall    = (op_r == OP_QUERY) && seen_hit && pend_v_r && !room;
  assign id_oor   = ({1'b0, cmd.id} >= (ID_W + 1)'(MAX_ITEMS));
  assign cmd_pop  = (state_r == B_IDLE) && !cmd_empty;

  // memory controls and result pushes
  always_comb begin
    fill_re    = (state_r == B_FRD);
    fill_we    = 1'b0;
    fill_waddr = cell_addr;
    fill_wdata = '0;
    slot_re    = (state_r == B_SRD) && (j_r != n_r);
    slot_we    = 1'b0;
    slot_waddr = slot_base + SAW'(fill_rd);
    slot_wdata = id_r;
    rect_re    = cmd_pop && (cmd.op == OP_REMOVE);
    rect_we    = (state_r == B_FEV) && (op_r == OP_ADD) && !chk_r && last_cell;
    oq_push    = 1'b0;
    oq_data    = '{found_id: '0, found_valid: 1'b0, last: 1'b1, status: status_r};

    if (state_r == B_CLR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_cnt_r;
    end
    if ((state_r == B_FEV) && (op_r == OP_ADD) && !chk_r) begin
      fill_we    = 1'b1;
      fill_wdata = fill_rd + FW'(1);
      slot_we    = 1'b1;
    end
    if ((state_r == B_SRD) && (op_r == OP_REMOVE) && (j_r == n_r) && found_r) begin
      fill_we    = 1'b1;
      fill_wdata = n_r - FW'(1);
    end
    if ((state_r == B_SEV) && (op_r == OP_REMOVE) && found_r) begin
      slot_we    = 1'b1;
      slot_waddr = slot_base + SAW'(j_r - FW'(1));
      slot_wdata = slot_rd;
    end

    // a new hit sends the one held back, the last hit goes out at the end
    if ((state_r == B_SEV) && (op_r == OP_QUERY) && seen_hit && pend_v_r && room) begin
      oq_push = 1'b1;
      oq_data = '{found_id: ID_W'(pend_id_r), found_valid: 1'b1, last: 1'b0,
                  status: status_r};
    end
    if ((state_r == B_DONE) && room) begin
      oq_push = 1'b1;
      if ((op_r == OP_QUERY) && pend_v_r) begin
        oq_data = '{found_id: ID_W'(pend_id_r), found_valid: 1'b1, last: 1'b1,
                    status: status_r};
      end
    end
  end

  // per-cell fill counts
  ugsi_ram #(.WIDTH(FW), .DEPTH(NCELL)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (cell_addr),
    .rdata (fill_rd)
  );

  // per-cell item slots
  ugsi_ram #(.WIDTH(IDW), .DEPTH(NSLOT)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rd)
  );

  // cell range of each filed item
  ugsi_ram #(.WIDTH(RW), .DEPTH(MAX_ITEMS)) u_rect (
    .clk   (clk),
    .we    (rect_we),
    .waddr (id_r),
    .wdata ({x0_r, x1_r, y0_r, y1_r}),
    .re    (rect_re),
    .raddr (cmd.id[IDW-1:0]),
    .rdata (rect_rd)
  );

  // result queue
  assign oq_pop    = res_pop && !res_empty;
  assign res_empty = (oq_cnt_r == 3'd0);
  assign res       = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wp_r] <= oq_data;
    end
  end

  // cell walk sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_CLR;
      clr_cnt_r  <= '0;
      clr_emit_r <= 1'b0;
      present_r  <= '0;
      seen_r     <= '0;
      pend_v_r   <= 1'b0;
      oq_wp_r    <= '0;
      oq_rp_r    <= '0;
      oq_cnt_r   <= '0;
    end else begin
      if (oq_push) begin
        oq_wp_r <= oq_wp_r + 2'd1;
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + 2'd1;
      end
      oq_cnt_r <= oq_cnt_r + 3'(oq_push ? 1 : 0) - 3'(oq_pop ? 1 : 0);

      unique case (state_r)
        B_CLR: begin
          clr_cnt_r <= clr_cnt_r + CAW'(1);
          status_r  <= ST_OK;
          if (clr_cnt_r == CAW'(NCELL - 1)) begin
            state_r <= clr_emit_r ? B_DONE : B_IDLE;
          end
        end
        B_IDLE: begin
          if (!cmd_empty) begin
            op_r     <= cmd.op;
            id_r     <= cmd.id[IDW-1:0];
            x0_r     <= cmd.x0[QW-1:0];
            x1_r     <= cmd.x1[QW-1:0];
            y0_r     <= cmd.y0[QW-1:0];
            y1_r     <= cmd.y1[QW-1:0];
            cx_r     <= cmd.x0[QW-1:0];
            cy_r     <= cmd.y0[QW-1:0];
            chk_r    <= 1'b1;
            pend_v_r <= 1'b0;
            status_r <= cmd.clipped ? ST_CLIPPED : ST_OK;
            unique case (cmd.op)
              OP_ADD: begin
                if (id_oor) begin
                  status_r <= ST_ABSENT;
                  state_r  <= B_DONE;
                end else if (present_r[cmd.id[IDW-1:0]]) begin
                  status_r <= ST_PRESENT;
                  state_r  <= B_DONE;
                end else if (cmd.empty) begin
                  state_r <= B_DONE;
                end else begin
                  state_r <= B_FRD;
                end
              end
              OP_REMOVE: begin
                if (id_oor || !present_r[cmd.id[IDW-1:0]]) begin
                  status_r <= ST_ABSENT;
                  state_r  <= B_DONE;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= B_RECT;
                end
              end
              OP_QUERY: begin
                seen_r  <= '0;
                state_r <= cmd.empty ? B_DONE : B_FRD;
              end
              OP_CLEAR: begin
                present_r  <= '0;
                clr_cnt_r  <= '0;
                clr_emit_r <= 1'b1;
                state_r    <= B_CLR;
              end
            endcase
          end
        end
        B_RECT: begin
          {x0_r, x1_r, y0_r, y1_r} <= rect_rd;
          cx_r    <= rect_rd[RW-1 -: QW];
          cy_r    <= rect_rd[2*QW-1 -: QW];
          state_r <= B_FRD;
        end
        B_FRD: begin
          state_r <= B_FEV;
        end
        B_FEV: begin
          n_r     <= fill_rd;
          j_r     <= '0;
          found_r <= 1'b0;
          if (op_r == OP_ADD) begin
            if (chk_r && (fill_rd >= FW'(CELL_SLOTS))) begin
              status_r <= ST_FULL;
              state_r  <= B_DONE;
            end else if (last_cell) begin
              if (chk_r) begin
                chk_r   <= 1'b0;
                cx_r    <= x0_r;
                cy_r    <= y0_r;
                state_r <= B_FRD;
              end else begin
                present_r[id_r] <= 1'b1;
                state_r         <= B_DONE;
              end
            end else begin
              cx_r    <= cx_adv;
              cy_r    <= cy_adv;
              state_r <= B_FRD;
            end
          end else begin
            state_r <= B_SRD;
          end
        end
        B_SRD: begin
          if (j_r == n_r) begin
            if (last_cell) begin
              if (op_r == OP_REMOVE) begin
                present_r[id_r] <= 1'b0;
              end
              state_r <= B_DONE;
            end else begin
              cx_r    <= cx_adv;
              cy_r    <= cy_adv;
              state_r <= B_FRD;
            end
          end else begin
            state_r <= B_SEV;
          end
        end
        B_SEV: begin
          if (op_r == OP_REMOVE) begin
            if (!found_r && (slot_rd == id_r)) begin
              found_r <= 1'b1;
            end
            j_r     <= j_r + FW'(1);
            state_r <= B_SRD;
          end else if (!stall) begin
            if (seen_hit) begin
              seen_r[slot_rd] <= 1'b1;
              pend_id_r       <= slot_rd;
              pend_v_r        <= 1'b1;
            end
            j_r     <= j_r + FW'(1);
            state_r <= B_SRD;
          end
        end
        B_DONE: begin
          if (room) begin
            clr_emit_r <= 1'b0;
            state_r    <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // the result queue is never written when full
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_cnt_r != 3'(OQ_DEPTH)))
    else $error("result queue overflow");

  // no request is taken during a clearing pass
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CLR) |-> !cmd_pop)
    else $error("request taken while clearing");

  // a cell never holds more than its slots
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> (fill_wdata <= FW'(CELL_SLOTS)))
    else $error("cell fill beyond slot count");

  // shifting a row down never starts at the first slot
  a_shift_index: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == B_SEV) && (op_r == OP_REMOVE) && found_r) |-> (j_r != '0))
    else $error("row shift at slot zero");

  // the final result of a request returns the walk to idle
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == B_DONE) && room) |=> (state_r == B_IDLE))
    else $error("final result did not end the request");
`endif

endmodule
